/* design/hdsc_pkg.sv */
// Shared types and constants for the hall-period deadband speed controller.
// Used by hdsc_div and hall_rpm_deadband_step_speed_control_core; no dependencies.
package hdsc_pkg;

  localparam int MAGNETS = 2;

  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] RPM_NUM = DIV_W'(60000000 * MAGNETS);
  localparam logic [DIV_W-1:0] DEG_DIV = DIV_W'(MAGNETS * 360);
  localparam logic [DIV_W-1:0] PCT_DIV = DIV_W'(100);
  localparam logic [26:0]      RPM_MAX = '1;
  localparam logic [6:0]       DUTY_MAX = 7'd100;

  localparam logic [15:0] TARGET_RST  = 16'd0;
  localparam logic [7:0]  TOL_RST     = 8'd13;
  localparam logic [15:0] MAX_PWM_RST = 16'd255;

  typedef enum logic [1:0] {
    CFG_TARGET,
    CFG_TOL,
    CFG_MAX_PWM
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_HALL,
    KIND_ADJUST,
    KIND_DEGREE,
    KIND_SPARE
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RPM_START,
    ST_RPM_WAIT,
    ST_CMP,
    ST_PWM_START,
    ST_PWM_WAIT,
    ST_DEG_START,
    ST_DEG_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/hdsc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hdsc_pkg (div_req_t, div_rsp_t, DIV_W).
module hdsc_div import hdsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;
  logic [DIV_W-1:0]  rem_next;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = trial >= {1'b0, dsr};
  assign rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == DIV_CW'(DIV_W - 1) && !req.start) |=> done)
    else $error("divider missed its done pulse");

endmodule

/* design/hall_rpm_deadband_step_speed_control_core.sv */
// Hall-period speed controller: rpm, deadband duty step, PWM level, degree timing.
// Depends on hdsc_pkg and hdsc_div.
// Each word runs the 32-step bit-serial divider for rpm (when a period is known), for the
// PWM level and, for a degree query with a known period, for the per-degree time.
// Flow: one word at a time; the next word is taken while a finished result waits at
// the output register.
// Reset (rst, synchronous): registers to defaults, no period known, duty 0.
module hall_rpm_deadband_step_speed_control_core import hdsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] time_us
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // [26:0] rpm, [33:27] duty_percent, [49:34] pwm_level,
                                 // [50] in_band, [82:51] remaining_us, [87:83] zero
);

  logic [15:0] target;
  logic [7:0]  tol;
  logic [15:0] max_pwm;

  logic [31:0] last_pulse_time;
  logic [31:0] pulse_period;
  logic        seen_first_pulse;
  logic [6:0]  duty;

  state_t      state;
  state_t      state_next;
  kind_t       kind;
  logic [31:0] t_r;
  logic [26:0] rpm_r;
  logic [15:0] pwm_r;
  logic        in_band_r;
  logic [31:0] remaining_r;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        accept;
  logic        load_out;
  logic [34:0] scaled;
  logic [24:0] lo;
  logic [24:0] hi;
  logic        below;
  logic        above;
  logic [22:0] pwm_prod;
  logic [31:0] since;
  logic [26:0] rpm_sat;

  hdsc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign scaled   = {rpm_r, 8'd0};
  assign lo       = target * (9'd256 - {1'b0, tol});
  assign hi       = target * (9'd256 + {1'b0, tol});
  assign below    = scaled < {10'd0, lo};
  assign above    = scaled > {10'd0, hi};
  assign pwm_prod = duty * max_pwm;
  assign since    = t_r - last_pulse_time;
  assign rpm_sat  = (div_rsp.quotient > {5'd0, RPM_MAX}) ? RPM_MAX : div_rsp.quotient[26:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      target  <= TARGET_RST;
      tol     <= TOL_RST;
      max_pwm <= MAX_PWM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET:  target  <= cfg_data;
        CFG_TOL:     tol     <= cfg_data[7:0];
        CFG_MAX_PWM: max_pwm <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_RPM_START;
      ST_RPM_START: state_next = (pulse_period == 32'd0) ? ST_CMP : ST_RPM_WAIT;
      ST_RPM_WAIT:  if (div_rsp.done) state_next = ST_CMP;
      ST_CMP:       state_next = ST_PWM_START;
      ST_PWM_START: state_next = ST_PWM_WAIT;
      ST_PWM_WAIT: begin
        if (div_rsp.done) begin
          state_next = (kind == KIND_DEGREE && pulse_period != 32'd0) ? ST_DEG_START
                                                                       : ST_FINISH;
        end
      end
      ST_DEG_START: state_next = ST_DEG_WAIT;
      ST_DEG_WAIT:  if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = (state == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = RPM_NUM;
    div_req.divisor  = pulse_period;
    unique case (state)
      ST_RPM_START: div_req.start = (pulse_period != 32'd0);
      ST_PWM_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {9'd0, pwm_prod};
        div_req.divisor  = PCT_DIV;
      end
      ST_DEG_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = pulse_period;
        div_req.divisor  = DEG_DIV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time  <= 32'd0;
      pulse_period     <= 32'd0;
      seen_first_pulse <= 1'b0;
      duty             <= 7'd0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept && kind_t'(s_tuser) == KIND_HALL) begin
        if (seen_first_pulse) pulse_period <= s_tdata - last_pulse_time;
        last_pulse_time  <= s_tdata;
        seen_first_pulse <= 1'b1;
      end
      if (state == ST_CMP && kind == KIND_ADJUST) begin
        if (below) begin
          if (duty < DUTY_MAX) duty <= duty + 7'd1;
        end else if (above) begin
          if (duty != 7'd0) duty <= duty - 7'd1;
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= kind_t'(s_tuser);
      t_r  <= s_tdata;
    end
    if (state == ST_RPM_START && pulse_period == 32'd0) rpm_r <= 27'd0;
    if (state == ST_RPM_WAIT && div_rsp.done) rpm_r <= rpm_sat;
    if (state == ST_CMP) in_band_r <= !below && !above;
    if (state == ST_PWM_WAIT && div_rsp.done) begin
      pwm_r       <= div_rsp.quotient[15:0];
      remaining_r <= 32'd0;
    end
    if (state == ST_DEG_WAIT && div_rsp.done) begin
      remaining_r <= (div_rsp.quotient > since) ? (div_rsp.quotient - since) : 32'd0;
    end
    if (load_out) begin
      m_tdata <= {5'd0, remaining_r, in_band_r, pwm_r, duty, rpm_r};
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst) duty <= DUTY_MAX)
    else $error("duty above full scale");
  a_duty_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && duty != $past(duty)) |->
      (duty == $past(duty) + 7'd1 || duty == $past(duty) - 7'd1))
    else $error("duty moved by more than one step");
  a_duty_when: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CMP) |=> $stable(duty))
    else $error("duty changed outside the compare step");
  a_period_when: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(pulse_period) && $stable(last_pulse_time))
    else $error("pulse timing changed without an input word");

endmodule

/* dv/hall_rpm_deadband_step_speed_control_core_tb.sv */
// Self-checking bench for hall_rpm_deadband_step_speed_control_core: directed table,
// then randomised pulse/tick/query runs over several register settings and flow modes.
// Depends on hdsc_pkg and the core RTL.
module hall_rpm_deadband_step_speed_control_core_tb;
  import hdsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned RPM_SCALE = 60_000_000 * MAGNETS;
  localparam longint unsigned RPM_CEIL  = (64'd1 << 27) - 1;
  localparam int unsigned     DEG_STEPS = MAGNETS * 360;
  localparam int              STALL_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] remaining_us;
    logic        in_band;
    logic [15:0] pwm_level;
    logic [6:0]  duty_pct;
    logic [26:0] rpm;
  } status_word_t;

  typedef struct packed {
    logic         typed;
    status_word_t exp;
    kind_t        kind;
    logic [31:0]  t;
  } stim_word_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    idx;
    logic [15:0] val;
    stim_word_t  w;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  hall_rpm_deadband_step_speed_control_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller shadow state
  longint unsigned m_target = 0, m_tol = 13, m_maxpwm = 255;
  logic [31:0]     m_last = '0, m_period = '0;
  logic            m_seen = 1'b0;
  int unsigned     m_duty = 0;

  stim_word_t   word_backlog [$];
  status_word_t status_due [$];
  stim_word_t   cur_word;
  int           send_idle_pct = 0, recv_stall_pct = 0;
  int           errors = 0, quiet_cycles = 0;
  logic [31:0]  gen_time, last_hall, last_per;
  plan_row_t    plan [24];

  function automatic status_word_t next_status(kind_t k, logic [31:0] t);
    longint unsigned rpm_q, scaled, lo, hi;
    logic [31:0]     per_deg, since;
    logic            below, above;
    status_word_t    s;
    s = '0;
    if (k == KIND_HALL) begin
      if (m_seen) m_period = t - m_last;
      m_last = t;
      m_seen = 1'b1;
    end
    rpm_q = (m_period == 0) ? 0 : RPM_SCALE / m_period;
    if (rpm_q > RPM_CEIL) rpm_q = RPM_CEIL;
    scaled = rpm_q * 256;
    lo = m_target * (256 - m_tol);
    hi = m_target * (256 + m_tol);
    below = scaled < lo;
    above = scaled > hi;
    case (k)
      KIND_ADJUST: begin
        if (below) begin
          if (m_duty < 100) m_duty++;
        end else if (above) begin
          if (m_duty > 0) m_duty--;
        end
      end
      KIND_DEGREE: begin
        if (m_period != 0) begin
          per_deg = m_period / DEG_STEPS;
          since = t - m_last;
          s.remaining_us = (per_deg > since) ? per_deg - since : '0;
        end
      end
      default: ;
    endcase
    s.rpm = rpm_q[26:0];
    s.duty_pct = m_duty[6:0];
    s.pwm_level = 16'((m_duty * m_maxpwm) / 100);
    s.in_band = !below && !above;
    return s;
  endfunction

  function automatic bit field_ok(string fname, longint unsigned want, longint unsigned got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    return 1'b0;
  endfunction

  function automatic plan_row_t row_cfg(cfg_idx_t idx, logic [15:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t row_word(kind_t k, logic [31:0] t);
    plan_row_t r;
    r = '0;
    r.w.kind = k;
    r.w.t = t;
    return r;
  endfunction

  function automatic plan_row_t row_known(kind_t k, logic [31:0] t, int unsigned rpm,
                                          int unsigned duty, int unsigned pwm,
                                          int unsigned inb, int unsigned rem);
    plan_row_t r;
    r = row_word(k, t);
    r.w.typed = 1'b1;
    r.w.exp.rpm = rpm[26:0];
    r.w.exp.duty_pct = duty[6:0];
    r.w.exp.pwm_level = pwm[15:0];
    r.w.exp.in_band = inb[0];
    r.w.exp.remaining_us = rem;
    return r;
  endfunction

  // input side, output check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        status_word_t p;
        p = next_status(kind_t'(s_tuser), s_tdata);
        status_due.push_back(cur_word.typed ? cur_word.exp : p);
      end
      if (m_tvalid && m_tready) begin
        if (status_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          status_word_t e, a;
          e = status_due.pop_front();
          a = status_word_t'(m_tdata[82:0]);
          errors += !field_ok("rpm", e.rpm, a.rpm);
          errors += !field_ok("duty_percent", e.duty_pct, a.duty_pct);
          errors += !field_ok("pwm_level", e.pwm_level, a.pwm_level);
          errors += !field_ok("in_band", e.in_band, a.in_band);
          errors += !field_ok("remaining_us", e.remaining_us, a.remaining_us);
          errors += !field_ok("pad", 0, m_tdata[87:83]);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = word_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= cur_word.t;
          s_tuser <= cur_word.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);

      if ((word_backlog.size() != 0 || s_tvalid || status_due.size() != 0) &&
          !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress", $time);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (word_backlog.size() != 0 || s_tvalid || status_due.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TARGET:  m_target = val;
      CFG_TOL:     m_tol = val[7:0];
      CFG_MAX_PWM: m_maxpwm = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // regime: 0 near target, 1 tiny periods, 2 any period, 3 long periods
  task automatic run_phase(logic [15:0] tgt, logic [7:0] tol, logic [15:0] mpwm,
                           int idle, int stall, int regime, int n);
    stim_word_t  w;
    logic [31:0] per, base;
    int          r;
    wait_idle();
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_TOL, {8'd0, tol});
    write_reg(CFG_MAX_PWM, mpwm);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      w = '0;
      r = $urandom_range(99);
      if (r < 12) begin
        w.kind = kind_t'($urandom_range(3));
        w.t = $urandom;
      end else if (r < 42) begin
        case (regime)
          0: begin
            base = (tgt == 0) ? 32'd60000 : 32'd120000000 / tgt;
            per = base - base / 16 + $urandom_range(base / 8);
          end
          1: per = $urandom_range(300, 1);
          2: per = $urandom;
          default: per = $urandom_range(10000000, 100000);
        endcase
        if ($urandom_range(99) < 3) per = '0;
        gen_time += per;
        last_hall = gen_time;
        last_per = per;
        w.kind = KIND_HALL;
        w.t = gen_time;
      end else if (r < 80) begin
        w.kind = KIND_ADJUST;
        w.t = gen_time + $urandom_range(50);
      end else if (r < 97) begin
        w.kind = KIND_DEGREE;
        w.t = last_hall + $urandom_range((last_per / DEG_STEPS) * 2 + 2);
      end else begin
        w.kind = KIND_SPARE;
        w.t = $urandom;
      end
      word_backlog.push_back(w);
    end
  endtask

  initial begin
    plan = '{
      row_known(KIND_ADJUST, 32'd0, 0, 0, 0, 1, 0),
      row_known(KIND_DEGREE, 32'd5, 0, 0, 0, 1, 0),
      row_known(KIND_SPARE, 32'hFFFF_FFFF, 0, 0, 0, 1, 0),
      row_known(KIND_HALL, 32'hFFFF_FFFF, 0, 0, 0, 1, 0),   // first pulse
      row_known(KIND_HALL, 32'hFFFF_FFFF, 0, 0, 0, 1, 0),   // same time, no period
      row_known(KIND_HALL, 32'd59999, 2000, 0, 0, 0, 0),    // wraps, period 60000
      row_cfg(CFG_TARGET, 16'hFFFF),
      row_cfg(CFG_TOL, 16'd0),
      row_cfg(CFG_MAX_PWM, 16'hFFFF),
      row_known(KIND_ADJUST, 32'd70000, 2000, 1, 655, 0, 0),
      row_known(KIND_DEGREE, 32'd60039, 2000, 1, 655, 0, 43),
      row_known(KIND_DEGREE, 32'd60082, 2000, 1, 655, 0, 0),
      row_known(KIND_DEGREE, 32'd60081, 2000, 1, 655, 0, 1),
      row_known(KIND_HALL, 32'd60000, 120000000, 1, 655, 0, 0),  // period 1, top rpm
      row_known(KIND_ADJUST, 32'd60001, 120000000, 0, 0, 0, 0),
      row_known(KIND_ADJUST, 32'd60002, 120000000, 0, 0, 0, 0),  // duty held at 0
      row_word(KIND_DEGREE, 32'd60000),
      row_cfg(CFG_MAX_PWM, 16'd0),
      row_cfg(CFG_TOL, 16'd255),
      row_cfg(CFG_TARGET, 16'd1),
      row_known(KIND_HALL, 32'd59999, 0, 0, 0, 0, 0),       // longest period, rpm 0
      row_known(KIND_ADJUST, 32'h8000_0000, 0, 1, 0, 0, 0),
      row_known(KIND_DEGREE, 32'd59999, 0, 1, 0, 0, 5965232),
      row_known(KIND_SPARE, 32'd0, 0, 1, 0, 0, 0)
    };
    gen_time = $urandom;
    last_hall = gen_time;
    last_per = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        word_backlog.push_back(plan[i].w);
      end
    end

    run_phase(16'hFFFF, 8'd0, 16'hFFFF, 0, 0, 3, 300);   // duty climbs to full
    run_phase(16'd0, 8'd255, 16'd1, 63, 0, 1, 300);      // duty falls to zero
    run_phase(16'($urandom_range(65535)), 8'($urandom_range(255)), 16'd0,
              0, 63, 0, 200);
    run_phase(16'($urandom_range(65535)), 8'd255, 16'($urandom_range(65535)),
              9, 9, 0, 200);
    run_phase(16'($urandom_range(65535)), 8'($urandom_range(255)),
              16'($urandom_range(65535)), 0, 0, 2, 200);
    run_phase(16'($urandom_range(65535)), 8'd13, 16'd255, 63, 0, 0, 150);
    run_phase(16'($urandom_range(65535)), 8'($urandom_range(255)), 16'd1,
              0, 63, 3, 150);
    run_phase(16'd1, 8'd255, 16'hFFFF, 9, 9, 2, 100);

    wait_idle();
    repeat (150) @(posedge clk);
    if (errors == 0 && status_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
